// ===== src/ecgpp_pkg.sv =====
// ----------------------------------------------------------------------------
// ecgpp_pkg
// shared types and constants for the sensor packet parser
// ----------------------------------------------------------------------------
package ecgpp_pkg;

  // byte values and lengths of the packet format
  localparam logic [7:0] SYNC_BYTE    = 8'hAA;
  localparam logic [7:0] STATUS_LEN   = 8'h12;
  localparam logic [7:0] GOOD_QUALITY = 8'hC8;
  localparam logic [4:0] RAW_LEN_RST  = 5'd4;

  // payload byte positions
  localparam logic [4:0] RAW_HI_POS  = 5'd2;
  localparam logic [4:0] RAW_LO_POS  = 5'd3;
  localparam logic [4:0] STAT_Q_POS  = 5'd1;
  localparam logic [4:0] STAT_HR_POS = 5'd3;

  // packet kinds
  localparam logic KIND_RAW    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // output word layout
  localparam int TDATA_W = 40;
  localparam int PAD_W   = 6;

  typedef struct packed {
    logic               packet_kind;
    logic               checksum_ok;
    logic               sample_valid;
    logic signed [15:0] sample;
    logic [7:0]         signal_quality;
    logic [7:0]         heart_rate;
  } res_t;

endpackage

// ===== src/ecgpp_parser.sv =====
// ----------------------------------------------------------------------------
// ecgpp_parser
// input byte register, packet state machine and result forming
// ----------------------------------------------------------------------------
module ecgpp_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wen,
  input  logic [4:0]    cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  output logic          res_valid,
  input  logic          res_ready,
  output ecgpp_pkg::res_t res
);
  import ecgpp_pkg::*;

  typedef enum logic [4:0] {
    ST_SYNC1   = 5'b00001,
    ST_SYNC2   = 5'b00010,
    ST_LEN     = 5'b00100,
    ST_PAYLOAD = 5'b01000,
    ST_CHECK   = 5'b10000
  } phase_t;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       step;

  logic [4:0] raw_length;
  phase_t     phase, phase_next;
  logic [4:0] byte_index, byte_index_next;
  logic [7:0] running_sum, running_sum_next;
  logic       packet_is_status, packet_is_status_next;
  logic [4:0] body_length, body_length_next;
  logic [7:0] high_byte, high_byte_next;
  logic [7:0] low_byte, low_byte_next;
  logic [7:0] quality_hold, quality_hold_next;
  logic [7:0] rate_hold, rate_hold_next;

  logic       ok;
  logic [4:0] idx_inc;

  // input stage advances whenever the result side can take a word
  assign in_ready  = !byte_valid || res_ready;
  assign step      = byte_valid && res_ready;
  assign res_valid = byte_valid && (phase == ST_CHECK);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_data <= in_byte;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_length <= RAW_LEN_RST;
    end else if (cfg_wen) begin
      raw_length <= cfg_wdata;
    end
  end

  assign ok      = (byte_data == ~running_sum);
  assign idx_inc = byte_index + 5'd1;

  // next state of the packet walk
  always_comb begin
    phase_next            = phase;
    byte_index_next       = byte_index;
    running_sum_next      = running_sum;
    packet_is_status_next = packet_is_status;
    body_length_next      = body_length;
    high_byte_next        = high_byte;
    low_byte_next         = low_byte;
    quality_hold_next     = quality_hold;
    rate_hold_next        = rate_hold;
    case (phase)
      ST_SYNC1: begin
        if (byte_data == SYNC_BYTE) phase_next = ST_SYNC2;
      end
      ST_SYNC2: begin
        phase_next = (byte_data == SYNC_BYTE) ? ST_LEN : ST_SYNC1;
      end
      ST_LEN: begin
        running_sum_next = 8'd0;
        byte_index_next  = 5'd0;
        high_byte_next   = 8'd0;
        low_byte_next    = 8'd0;
        if (byte_data == {3'd0, raw_length} || byte_data == STATUS_LEN) begin
          packet_is_status_next = (byte_data != {3'd0, raw_length});
          body_length_next      = byte_data[4:0];
          phase_next = (byte_data[4:0] == 5'd0) ? ST_CHECK : ST_PAYLOAD;
        end else begin
          phase_next = ST_SYNC1;
        end
      end
      ST_PAYLOAD: begin
        running_sum_next = running_sum + byte_data;
        if (packet_is_status) begin
          if (byte_index == STAT_Q_POS)  high_byte_next = byte_data;
          if (byte_index == STAT_HR_POS) low_byte_next  = byte_data;
        end else begin
          if (byte_index == RAW_HI_POS) high_byte_next = byte_data;
          if (byte_index == RAW_LO_POS) low_byte_next  = byte_data;
        end
        byte_index_next = idx_inc;
        if (idx_inc >= body_length) phase_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (packet_is_status && ok) begin
          quality_hold_next = high_byte;
          rate_hold_next    = low_byte;
        end
        phase_next       = ST_SYNC1;
        byte_index_next  = 5'd0;
        running_sum_next = 8'd0;
      end
      default: begin
        phase_next = ST_SYNC1;
      end
    endcase
  end

  // result of the checksum byte
  always_comb begin
    res.packet_kind    = packet_is_status ? KIND_STATUS : KIND_RAW;
    res.checksum_ok    = ok;
    res.sample_valid   = !packet_is_status && ok && (quality_hold == GOOD_QUALITY);
    res.sample         = res.sample_valid ? $signed({high_byte, low_byte}) : 16'sd0;
    res.signal_quality = quality_hold_next;
    res.heart_rate     = rate_hold_next;
  end

  // packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= ST_SYNC1;
      byte_index       <= 5'd0;
      running_sum      <= 8'd0;
      packet_is_status <= 1'b0;
      body_length      <= 5'd0;
      high_byte        <= 8'd0;
      low_byte         <= 8'd0;
      quality_hold     <= 8'd0;
      rate_hold        <= 8'd0;
    end else if (step) begin
      phase            <= phase_next;
      byte_index       <= byte_index_next;
      running_sum      <= running_sum_next;
      packet_is_status <= packet_is_status_next;
      body_length      <= body_length_next;
      high_byte        <= high_byte_next;
      low_byte         <= low_byte_next;
      quality_hold     <= quality_hold_next;
      rate_hold        <= rate_hold_next;
    end
  end

endmodule

// ===== src/ecgpp_out_reg.sv =====
// ----------------------------------------------------------------------------
// ecgpp_out_reg
// result register that drives the output stream
// ----------------------------------------------------------------------------
module ecgpp_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          res_valid,
  output logic                          res_ready,
  input  ecgpp_pkg::res_t               res,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ecgpp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tuser
);
  import ecgpp_pkg::*;

  logic full;
  res_t held;

  // register may load while its current word drains
  assign res_ready = !full || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (res_ready) begin
      full <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  assign m_axis_tvalid = full;
  assign m_axis_tuser  = held.packet_kind;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, held.heart_rate, held.signal_quality,
                          held.sample, held.sample_valid, held.checksum_ok};

endmodule

// ===== src/ecg_sensor_packet_parser_core.sv =====
// ----------------------------------------------------------------------------
// ecg_sensor_packet_parser_core
// byte stream parser for sensor packets with sample and status results
// ----------------------------------------------------------------------------
// Takes one received serial byte per cycle unless stalled, and emits one
// result word per completed packet (on its checksum byte). A byte passes an
// input register, then the packet state machine and a result register that
// offers the word. The input side stalls only while the result register holds
// a word the output side has not taken. The user must write raw_length via
// cfg_wen/cfg_wdata while the stream is idle; the block does not enforce this.
module ecg_sensor_packet_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [4:0]                    cfg_wdata,      // raw_length
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // checksum_ok, sample_valid, sample[15:0], signal_quality[7:0],
  // heart_rate[7:0], zero pad
  output logic [ecgpp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tuser    // packet_kind
);
  import ecgpp_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res;

  ecgpp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ecgpp_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== src/ecgpp_checker.sv =====
// ----------------------------------------------------------------------------
// ecgpp_checker
// port level checks of the packet parser result stream
// ----------------------------------------------------------------------------
module ecgpp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ecgpp_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import ecgpp_pkg::*;

  // a pending word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped before taken");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:TDATA_W-PAD_W] == '0)
    else $error("nonzero pad bits in result word");

  // invalid sample reads as zero
  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[17:2] == 16'd0)
    else $error("sample nonzero while not valid");

  // a valid sample needs a raw packet and good checksum
  a_valid_raw: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |->
      m_axis_tuser == KIND_RAW && m_axis_tdata[0])
    else $error("sample valid on status or bad checksum packet");

  // a valid sample needs good contact quality
  a_valid_quality: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[25:18] == GOOD_QUALITY)
    else $error("sample valid without good contact quality");

endmodule

bind ecg_sensor_packet_parser_core ecgpp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/ecg_packet_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecg_packet_checker
// watches both streams of the packet parser, predicts and compares results
// ----------------------------------------------------------------------------
// Every byte word accepted on the input stream is run through a local model of
// the packet state machine. A completed packet queues the result word the
// parser must send. Each word taken on the output stream is compared field by
// field with the oldest queued packet result. Writes of raw_length are tracked
// so that the model decodes lengths the same way the parser does.
module ecg_packet_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [4:0]                    cfg_wdata,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [ecgpp_pkg::TDATA_W-1:0] m_axis_tdata,
  input  logic                          m_axis_tuser,
  output int                            mismatch_count,
  output int                            pending_count
);
  import ecgpp_pkg::*;

  typedef enum logic [2:0] {
    HUNT_SYNC1,
    HUNT_SYNC2,
    GET_LENGTH,
    GET_PAYLOAD,
    GET_CHECKSUM
  } parse_phase_t;

  typedef struct packed {
    logic               kind;
    logic               sum_ok;
    logic               smp_valid;
    logic signed [15:0] smp;
    logic [7:0]         quality;
    logic [7:0]         rate;
  } packet_result_t;

  // local copy of the parser state and its length register
  parse_phase_t   phase;
  logic [4:0]     pos;
  logic [7:0]     sum;
  logic           is_status;
  logic [4:0]     body_len;
  logic [7:0]     hi_byte;
  logic [7:0]     lo_byte;
  logic [7:0]     quality_reg;
  logic [7:0]     rate_reg;
  logic [4:0]     raw_len;

  packet_result_t expected_packets [$];
  packet_result_t got;
  packet_result_t want;

  // advance the model by one received byte
  task automatic parse_rx_byte(input logic [7:0] b);
    packet_result_t res;
    case (phase)
      HUNT_SYNC1: begin
        if (b == SYNC_BYTE) phase = HUNT_SYNC2;
      end
      HUNT_SYNC2: begin
        phase = (b == SYNC_BYTE) ? GET_LENGTH : HUNT_SYNC1;
      end
      GET_LENGTH: begin
        sum     = '0;
        pos     = '0;
        hi_byte = '0;
        lo_byte = '0;
        if (b == {3'b000, raw_len} || b == STATUS_LEN) begin
          // raw wins when raw_length is set to the status length
          is_status = (b != {3'b000, raw_len});
          body_len  = b[4:0];
          phase     = (body_len == 5'd0) ? GET_CHECKSUM : GET_PAYLOAD;
        end else begin
          phase = HUNT_SYNC1;
        end
      end
      GET_PAYLOAD: begin
        sum = sum + b;
        if (is_status) begin
          if (pos == STAT_Q_POS) hi_byte = b;
          if (pos == STAT_HR_POS) lo_byte = b;
        end else begin
          if (pos == RAW_HI_POS) hi_byte = b;
          if (pos == RAW_LO_POS) lo_byte = b;
        end
        pos = pos + 5'd1;
        if (pos >= body_len) phase = GET_CHECKSUM;
      end
      GET_CHECKSUM: begin
        res.kind      = is_status ? KIND_STATUS : KIND_RAW;
        res.sum_ok    = (b == ~sum);
        res.smp_valid = 1'b0;
        res.smp       = '0;
        // a status packet updates the held values only when intact
        if (is_status) begin
          if (res.sum_ok) begin
            quality_reg = hi_byte;
            rate_reg    = lo_byte;
          end
        end else if (res.sum_ok && quality_reg == GOOD_QUALITY) begin
          res.smp_valid = 1'b1;
          res.smp       = {hi_byte, lo_byte};
        end
        res.quality = quality_reg;
        res.rate    = rate_reg;
        expected_packets.push_back(res);
        phase = HUNT_SYNC1;
        pos   = '0;
        sum   = '0;
      end
      default: phase = HUNT_SYNC1;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase       = HUNT_SYNC1;
      pos         = '0;
      sum         = '0;
      is_status   = 1'b0;
      body_len    = '0;
      hi_byte     = '0;
      lo_byte     = '0;
      quality_reg = '0;
      rate_reg    = '0;
      raw_len     = RAW_LEN_RST;
      expected_packets.delete();
      pending_count <= 0;
    end else begin
      // result word taken by the receiver
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = m_axis_tuser;
        got.sum_ok    = m_axis_tdata[0];
        got.smp_valid = m_axis_tdata[1];
        got.smp       = m_axis_tdata[17:2];
        got.quality   = m_axis_tdata[25:18];
        got.rate      = m_axis_tdata[33:26];
        if (expected_packets.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result word with no packet pending: %h kind %0d",
                     $realtime, m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end else begin
          want = expected_packets.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("%0t: packet result mismatch", $realtime);
              $display("  expected kind %0d ok %0d valid %0d sample %0d quality %0d rate %0d",
                       want.kind, want.sum_ok, want.smp_valid, want.smp,
                       want.quality, want.rate);
              $display("  actual   kind %0d ok %0d valid %0d sample %0d quality %0d rate %0d",
                       got.kind, got.sum_ok, got.smp_valid, got.smp,
                       got.quality, got.rate);
            end
            mismatch_count++;
          end
        end
      end
      // byte word taken by the parser
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
      // register write, only done while the stream is quiet
      if (cfg_wen) raw_len = cfg_wdata;
      pending_count <= expected_packets.size();
    end
  end

endmodule

// ===== bench/ecg_sensor_packet_parser_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecg_sensor_packet_parser_core_test
// stimulus and verdict for the sensor packet parser
// ----------------------------------------------------------------------------
// Feeds byte streams into the parser: a directed set of packets covering
// sample extremes, bad checksums, broken sync and unknown lengths, then
// random packet traffic under several raw_length settings and idle patterns.
// Results are checked by ecg_packet_checker; this module only drives the
// streams, holds the output side off once to fill the parser, and reports.
module ecg_sensor_packet_parser_core_test;
  import ecgpp_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_BYTES  = 25;
  localparam int PHASE_FRAMES = 2;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_wen       = 1'b0;
  logic [4:0]           cfg_wdata     = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tuser;

  int                   mismatch_count;
  int                   pending_count;

  // stimulus state
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  bit                   hold_go        = 1'b0;
  int                   hold_left      = 0;
  int                   quiet_cycles   = 0;
  int                   bytes_sent     = 0;
  int                   frames_sent    = 0;
  logic [4:0]           raw_len_now    = RAW_LEN_RST;
  logic [7:0]           body_q [$];
  logic [4:0]           cfg_plan [8];
  int                   send_idle_plan [4] = '{0, 66, 0, 37};
  int                   recv_stall_plan [4] = '{0, 0, 66, 37};

  always #1 clk = ~clk;

  ecg_sensor_packet_parser_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  ecg_packet_checker pkt_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one byte word, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // sync, length, body_q and checksum; bad_sum flips one checksum bit
  task automatic send_frame(input logic [7:0] len, input bit bad_sum);
    logic [7:0] sum;
    sum = '0;
    if (len == {3'b000, raw_len_now} || len == STATUS_LEN) frames_sent++;
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(len);
    foreach (body_q[n]) begin
      send_byte(body_q[n]);
      sum = sum + body_q[n];
    end
    send_byte(bad_sum ? (~sum ^ (8'h01 << $urandom_range(7))) : ~sum);
  endtask

  task automatic make_raw_body(input logic [7:0] hi, input logic [7:0] lo);
    body_q.delete();
    for (int n = 0; n < raw_len_now; n++)
      body_q.push_back((n == RAW_HI_POS) ? hi : (n == RAW_LO_POS) ? lo : 8'($urandom));
  endtask

  task automatic make_status_body(input logic [7:0] q, input logic [7:0] hr);
    body_q.delete();
    for (int n = 0; n < STATUS_LEN; n++)
      body_q.push_back((n == STAT_Q_POS) ? q : (n == STAT_HR_POS) ? hr : 8'($urandom));
  endtask

  // stop offering and wait until every packet result is back
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_raw_length(input logic [4:0] v);
    wait_quiet();
    cfg_wen     <= 1'b1;
    cfg_wdata   <= v;
    raw_len_now  = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // one random piece of traffic, mostly well-formed packets
  task automatic random_item();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 40) begin
      make_raw_body(8'($urandom), 8'($urandom));
      send_frame({3'b000, raw_len_now}, $urandom_range(9) == 0);
    end else if (pick < 65) begin
      make_status_body(($urandom_range(4) < 3) ? GOOD_QUALITY : 8'($urandom), 8'($urandom));
      send_frame(STATUS_LEN, $urandom_range(9) == 0);
    end else if (pick < 75) begin
      // arbitrary length byte with a short body
      body_q.delete();
      repeat ($urandom_range(4)) body_q.push_back(8'($urandom));
      send_frame(($urandom_range(1) == 1) ? 8'($urandom_range(31)) : 8'($urandom),
                 $urandom_range(1) == 1);
    end else if (pick < 85) begin
      // broken sync pair
      b = 8'($urandom);
      if (b == SYNC_BYTE) b = ~b;
      send_byte(SYNC_BYTE);
      send_byte(b);
    end else begin
      repeat ($urandom_range(1, 4))
        send_byte(($urandom_range(4) == 0) ? SYNC_BYTE : 8'($urandom));
    end
  endtask

  initial begin
    int start_bytes;
    int start_frames;
    cfg_plan = '{5'd17, 5'd0, 5'd18, 5'd2, 5'd31, RAW_LEN_RST,
                 5'($urandom_range(4, 17)), 5'($urandom_range(4, 17))};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: raw before any status means no contact quality yet
    make_raw_body(8'h12, 8'h34);
    send_frame({3'b000, raw_len_now}, 1'b0);
    make_status_body(GOOD_QUALITY, 8'hFF);
    send_frame(STATUS_LEN, 1'b0);
    // sample extremes
    make_raw_body(8'h7F, 8'hFF);
    send_frame({3'b000, raw_len_now}, 1'b0);
    make_raw_body(8'h80, 8'h00);
    send_frame({3'b000, raw_len_now}, 1'b0);
    make_raw_body(8'hFF, 8'hFF);
    send_frame({3'b000, raw_len_now}, 1'b0);
    make_raw_body(8'h00, 8'h00);
    send_frame({3'b000, raw_len_now}, 1'b0);
    // bad checksums, raw then status that must not store
    make_raw_body(8'h55, 8'hAA);
    send_frame({3'b000, raw_len_now}, 1'b1);
    make_status_body(8'h00, 8'h00);
    send_frame(STATUS_LEN, 1'b1);
    // broken sync, then a packet right behind it
    send_byte(SYNC_BYTE);
    send_byte(8'h55);
    make_raw_body(8'h01, 8'h23);
    send_frame({3'b000, raw_len_now}, 1'b0);
    // sync byte where the length belongs, then noise extremes
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    // unknown length
    body_q = '{8'h01, 8'h02, 8'h03};
    send_frame(8'h05, 1'b0);
    // quality dropped to zero invalidates the next sample
    make_status_body(8'h00, 8'h00);
    send_frame(STATUS_LEN, 1'b0);
    make_raw_body(8'h44, 8'h55);
    send_frame({3'b000, raw_len_now}, 1'b0);
    make_status_body(GOOD_QUALITY, 8'h48);
    send_frame(STATUS_LEN, 1'b0);

    // random traffic under each raw_length setting and idle pattern
    for (int p = 0; p < 8; p++) begin
      write_raw_length(cfg_plan[p]);
      send_idle_pct  = send_idle_plan[p % 4];
      recv_stall_pct = recv_stall_plan[p % 4];
      // long output hold-off while bytes keep coming
      if (p == 0) hold_go = 1'b1;
      start_bytes  = bytes_sent;
      start_frames = frames_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES || frames_sent - start_frames < PHASE_FRAMES)
        random_item();
    end

    wait_quiet();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
